// File: sv/base64_stream_decoder_unit_defines.svh
// assertion macros used by the b64d_serial module
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define B64D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be true outside reset
`define B64D_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define B64D_ASSERT(lbl, clk, rstn, prop, msg)
`define B64D_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: sv/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChPad     = 8'h3D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;

  // group positions
  localparam logic [1:0] PosTwo   = 2'd2;
  localparam logic [1:0] PosLast  = 2'd3;
  localparam logic [1:0] FullCnt  = 2'd3;

  // results of one character, slot 0 goes out first
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MaxResults-1:0][7:0] data;
    logic [MaxResults-1:0]      err;
  } bundle_t;

  // map a character to {valid, sextet}
  function automatic logic [6:0] sym_decode(logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    r = '0;
    t = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      t = c - ChUpperA;
      r = {1'b1, t[5:0]};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      t = c - 8'd71;
      r = {1'b1, t[5:0]};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      t = c + 8'd4;
      r = {1'b1, t[5:0]};
    end else if (c == ChPlus) begin
      r = {1'b1, 6'd62};
    end else if (c == ChSlash) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// File: sv/b64d_decode.sv
`timescale 1ns / 1ps

module b64d_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_char_i,
  input  logic              bundle_free_i,
  output logic              bundle_load_o,
  output b64d_pkg::bundle_t bundle_o
);

  logic             char_valid_q;
  logic [7:0]       char_q;
  logic [1:0]       pos_q, pos_d;
  logic [1:0]       scnt_q, scnt_d;
  logic [2:0][5:0]  store_q, store_d;
  logic             ignore_q, ignore_d;
  logic [6:0]       sym;
  logic [7:0]       b0, b1, b2;
  logic             advance;
  b64d_pkg::bundle_t res;

  // decode one character against the group state
  always_comb begin
    sym      = b64d_pkg::sym_decode(char_q);
    b0       = {store_q[0], store_q[1][5:4]};
    b1       = {store_q[1][3:0], store_q[2][5:2]};
    b2       = {store_q[2][1:0], sym[5:0]};
    res      = '0;
    pos_d    = pos_q;
    scnt_d   = scnt_q;
    store_d  = store_q;
    ignore_d = ignore_q;
    if (char_q != b64d_pkg::ChNewline) begin
      if (!ignore_q) begin
        if (char_q == b64d_pkg::ChPad) begin
          ignore_d = 1'b1;
          if (pos_q == b64d_pkg::PosTwo) begin
            res.cnt     = 2'd1;
            res.data[0] = b0;
          end else if (pos_q == b64d_pkg::PosLast) begin
            res.cnt     = 2'd2;
            res.data[0] = b0;
            res.data[1] = b1;
          end
        end else if (!sym[6]) begin
          res.cnt    = 2'd1;
          res.err[0] = 1'b1;
        end else if (scnt_q == b64d_pkg::FullCnt) begin
          res.cnt     = 2'd3;
          res.data[0] = b0;
          res.data[1] = b1;
          res.data[2] = b2;
        end else begin
          store_d[scnt_q] = sym[5:0];
          scnt_d          = scnt_q + 2'd1;
        end
      end
      // group end clears everything
      if (pos_q == b64d_pkg::PosLast) begin
        pos_d    = '0;
        scnt_d   = '0;
        store_d  = '0;
        ignore_d = 1'b0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  // characters with no results never wait for the result stage
  assign advance       = char_valid_q && ((res.cnt == 2'd0) || bundle_free_i);
  assign in_ready_o    = !char_valid_q || advance;
  assign bundle_load_o = advance && (res.cnt != 2'd0);
  assign bundle_o      = res;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      char_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
    end
  end

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      scnt_q   <= '0;
      store_q  <= '0;
      ignore_q <= 1'b0;
    end else if (advance) begin
      pos_q    <= pos_d;
      scnt_q   <= scnt_d;
      store_q  <= store_d;
      ignore_q <= ignore_d;
    end
  end

endmodule

// File: sv/b64d_serial.sv
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_defines.svh"

module b64d_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  b64d_pkg::bundle_t bundle_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              is_error_o,
  output logic              last_o
);

  logic              valid_q;
  logic [1:0]        idx_q;
  b64d_pkg::bundle_t bundle_q;
  logic              pop;
  logic              at_last;

  assign at_last = idx_q == (bundle_q.cnt - 2'd1);
  assign pop     = valid_q && out_ready_i;
  assign free_o  = !valid_q || (pop && at_last);

  // result beat from the held bundle
  assign out_valid_o = valid_q;
  assign out_byte_o  = bundle_q.data[idx_q];
  assign is_error_o  = bundle_q.err[idx_q];
  assign last_o      = at_last;

  // bundle register and slot index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  `B64D_ASSERT(a_idx_in_range, clk_i, rst_ni, valid_q |-> (idx_q < bundle_q.cnt), "slot index past count")
  `B64D_ASSERT_NEVER(a_load_busy, clk_i, rst_ni, load_i && !free_o, "bundle loaded while busy")
  `B64D_ASSERT_NEVER(a_load_empty, clk_i, rst_ni, load_i && (bundle_i.cnt == 2'd0), "empty bundle loaded")
  `B64D_ASSERT(a_idx_step, clk_i, rst_ni, (pop && !at_last && !load_i) |=> (valid_q && (idx_q == $past(idx_q) + 2'd1)), "slot index did not step")

endmodule

// File: sv/base64_stream_decoder_unit.sv
// flow: an accepted character is held in the input register and decoded from it;
//   its results are loaded into the result register, which offers the first beat
// throughput: one character per cycle; a character with results waits while the
//   previous bundle drains from the result register, one beat per ready cycle
// reset: asynchronous, clears group position, sextet store and all valid flags
`timescale 1ns / 1ps

module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_error_o,
  output logic       last_o
);

  b64d_pkg::bundle_t bundle;
  logic              bundle_load;
  logic              bundle_free;

  // character register and decode
  b64d_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .bundle_free_i (bundle_free),
    .bundle_load_o (bundle_load),
    .bundle_o      (bundle)
  );

  // result register, one beat per cycle while out_ready_i is high
  b64d_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (bundle_load),
    .bundle_i    (bundle),
    .free_o      (bundle_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_error_o  (is_error_o),
    .last_o      (last_o)
  );

endmodule
